### hdl/tcrs_pkg.sv
// Shared types, constants and codes for the ring-buffer text console.
package tcrs_pkg;

  // Screen geometry and ring-buffer size.
  localparam int unsigned COLS                   = 80;
  localparam int unsigned ROWS                   = 25;
  localparam int unsigned BUFFER_CELLS           = 16384;
  localparam int unsigned SCROLLS_BEFORE_COMPACT = 128;

  localparam int unsigned ADDR_W    = $clog2(BUFFER_CELLS);
  localparam int unsigned VIS_CELLS = ROWS * COLS;
  localparam int unsigned CNT_W     = $clog2(VIS_CELLS + 1);
  localparam int unsigned COL_W     = $clog2(COLS);
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned SCNT_W    = 8;

  // Column extraction by reciprocal multiplication; exact for any ADDR_W-bit distance.
  localparam int unsigned DIV_SHIFT = ADDR_W + 8;
  localparam longint unsigned DIV_MULT = ((64'd1 << DIV_SHIFT) + COLS - 1) / COLS;
  localparam int unsigned MULT_W    = $clog2(DIV_MULT + 1);
  localparam int unsigned PROD_W    = ADDR_W + MULT_W;
  localparam int unsigned QUOT_W    = PROD_W - DIV_SHIFT;

  // Character codes.
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // Request type codes.
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_ERASE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Decoded operation of an incoming request.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_CLEAR,
    OP_ERASE,
    OP_READ
  } op_e;

  // Datapath actions issued by the controller.
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_INIT_WR,
    ACT_PUT_WR,
    ACT_SCROLL,
    ACT_BLANK_WR,
    ACT_SCNT_INC,
    ACT_CP_INIT,
    ACT_CP_RD,
    ACT_CP1_WR,
    ACT_CP2_WR,
    ACT_CP_END,
    ACT_DIV1,
    ACT_DIV2,
    ACT_NEWLINE,
    ACT_RETURN,
    ACT_TAB_INIT,
    ACT_CLR_INIT,
    ACT_ERASE,
    ACT_READ,
    ACT_FINISH
  } act_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        char_code;
    logic [7:0]        char_attr;
    logic [4:0]        clear_row;
    logic [ADDR_W-1:0] cell_addr;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        cell_char;
    logic [7:0]        cell_attribute;
    logic [ADDR_W-1:0] cursor_pos;
    logic [ADDR_W-1:0] view_start_out;
    logic              did_scroll;
  } out_item_t;

  typedef struct packed {
    act_e act;
    logic put_space;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic need_scroll;
    logic blank_last;
    logic cnt_zero;
    logic scnt_hit;
    logic win_flat;
    logic cp1_last;
    logic cp2_last;
    logic tab_done;
    logic init_last;
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/tcrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcrs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/tcrs_ctrl.sv
// Controller state machine that sequences the console datapath.
module tcrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcrs_pkg::dp_stat_t stat_i,
  output tcrs_pkg::dp_cmd_t  cmd_o
);
  import tcrs_pkg::*;

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_PUT     = 5'd2;
  localparam logic [4:0] S_CHK     = 5'd3;
  localparam logic [4:0] S_BLANK   = 5'd4;
  localparam logic [4:0] S_SCNT    = 5'd5;
  localparam logic [4:0] S_CP_INIT = 5'd6;
  localparam logic [4:0] S_CP1_RD  = 5'd7;
  localparam logic [4:0] S_CP1_WR  = 5'd8;
  localparam logic [4:0] S_CP2_RD  = 5'd9;
  localparam logic [4:0] S_CP2_WR  = 5'd10;
  localparam logic [4:0] S_CP_END  = 5'd11;
  localparam logic [4:0] S_DIV1    = 5'd12;
  localparam logic [4:0] S_DIV2    = 5'd13;
  localparam logic [4:0] S_NL      = 5'd14;
  localparam logic [4:0] S_CR      = 5'd15;
  localparam logic [4:0] S_TAB     = 5'd16;
  localparam logic [4:0] S_CLR     = 5'd17;
  localparam logic [4:0] S_CLR_WR  = 5'd18;
  localparam logic [4:0] S_ERASE   = 5'd19;
  localparam logic [4:0] S_READ    = 5'd20;
  localparam logic [4:0] S_FIN     = 5'd21;

  logic [4:0] state_q, state_d;
  op_e        op_q, op_d;
  logic [4:0] post_put;

  // After a put and any scroll it caused, a tab may still owe spaces.
  assign post_put = (op_q == OP_TAB && !stat_i.tab_done) ? S_PUT : S_FIN;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath action.
  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    cmd_o.act       = ACT_NONE;
    cmd_o.put_space = (op_q == OP_TAB);
    unique case (state_q)
      S_INIT: begin
        cmd_o.act = ACT_INIT_WR;
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ACT_ACCEPT;
          op_d      = stat_i.op;
          unique case (stat_i.op)
            OP_PUT:                         state_d = S_PUT;
            OP_NEWLINE, OP_RETURN, OP_TAB:  state_d = S_DIV1;
            OP_CLEAR:                       state_d = S_CLR;
            OP_ERASE:                       state_d = S_ERASE;
            OP_READ:                        state_d = S_READ;
            default:                        state_d = S_FIN;
          endcase
        end
      end
      S_PUT: begin
        cmd_o.act = ACT_PUT_WR;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (stat_i.need_scroll) begin
          cmd_o.act = ACT_SCROLL;
          state_d   = S_BLANK;
        end else begin
          state_d = post_put;
        end
      end
      S_BLANK: begin
        cmd_o.act = ACT_BLANK_WR;
        if (stat_i.blank_last) state_d = S_SCNT;
      end
      S_SCNT: begin
        cmd_o.act = ACT_SCNT_INC;
        state_d   = stat_i.scnt_hit ? S_CP_INIT : post_put;
      end
      S_CP_INIT: begin
        cmd_o.act = ACT_CP_INIT;
        state_d   = stat_i.win_flat ? S_CP2_RD : S_CP1_RD;
      end
      S_CP1_RD: begin
        cmd_o.act = ACT_CP_RD;
        state_d   = S_CP1_WR;
      end
      S_CP1_WR: begin
        cmd_o.act = ACT_CP1_WR;
        state_d   = stat_i.cp1_last ? S_CP2_RD : S_CP1_RD;
      end
      S_CP2_RD: begin
        cmd_o.act = ACT_CP_RD;
        state_d   = S_CP2_WR;
      end
      S_CP2_WR: begin
        cmd_o.act = ACT_CP2_WR;
        state_d   = stat_i.cp2_last ? S_CP_END : S_CP2_RD;
      end
      S_CP_END: begin
        cmd_o.act = ACT_CP_END;
        state_d   = post_put;
      end
      S_DIV1: begin
        cmd_o.act = ACT_DIV1;
        state_d   = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.act = ACT_DIV2;
        priority if (op_q == OP_NEWLINE) state_d = S_NL;
        else if (op_q == OP_RETURN)      state_d = S_CR;
        else                             state_d = S_TAB;
      end
      S_NL: begin
        cmd_o.act = ACT_NEWLINE;
        state_d   = S_CHK;
      end
      S_CR: begin
        cmd_o.act = ACT_RETURN;
        state_d   = S_FIN;
      end
      S_TAB: begin
        cmd_o.act = ACT_TAB_INIT;
        state_d   = S_PUT;
      end
      S_CLR: begin
        cmd_o.act = ACT_CLR_INIT;
        state_d   = S_CLR_WR;
      end
      S_CLR_WR: begin
        if (stat_i.cnt_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.act = ACT_BLANK_WR;
          if (stat_i.blank_last) state_d = S_FIN;
        end
      end
      S_ERASE: begin
        cmd_o.act = ACT_ERASE;
        state_d   = S_FIN;
      end
      S_READ: begin
        cmd_o.act = ACT_READ;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.act = ACT_FINISH;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= OP_PUT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

### hdl/tcrs_dp.sv
// Datapath: cursor and window registers, cell memory, counters and result register.
module tcrs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcrs_pkg::dp_cmd_t   cmd_i,
  output tcrs_pkg::dp_stat_t  stat_o,
  input  tcrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcrs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import tcrs_pkg::*;

  in_item_t          req_q;
  out_item_t         out_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] cursor_q, vs_q, ptr_q;
  logic [SCNT_W-1:0] scnt_q;
  logic [7:0]        attr_q;
  logic              sc_q;
  logic [CNT_W-1:0]  cnt_q, idx_q, split_q;
  logic [PROD_W-1:0] prod_q;
  logic [COL_W-1:0]  col_q;
  logic [2:0]        tab_q;

  logic [ADDR_W-1:0] cur_off;
  logic [CELL_W-1:0] blank;
  logic [QUOT_W-1:0] quot;
  logic [CNT_W-1:0]  row_c, row_off;
  logic [ADDR_W:0]   tail_len;
  logic [SCNT_W:0]   scnt_inc;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Derived values.
  assign cur_off  = cursor_q - vs_q;
  assign blank    = {attr_q, CH_SPACE};
  assign quot     = prod_q[PROD_W-1:DIV_SHIFT];
  assign tail_len = (ADDR_W + 1)'(BUFFER_CELLS) - {1'b0, vs_q};
  assign scnt_inc = {1'b0, scnt_q} + (SCNT_W + 1)'(1);
  assign row_c    = (CNT_W'(req_q.clear_row) > CNT_W'(ROWS)) ? CNT_W'(ROWS)
                                                             : CNT_W'(req_q.clear_row);
  assign row_off  = CNT_W'(row_c * CNT_W'(COLS));

  // Request decode from the incoming payload.
  always_comb begin
    unique case (req_e'(in_data_i.req_type))
      REQ_PUT: begin
        priority if (in_data_i.char_code == CH_NL) stat_o.op = OP_NEWLINE;
        else if (in_data_i.char_code == CH_CR)     stat_o.op = OP_RETURN;
        else if (in_data_i.char_code == CH_TAB)    stat_o.op = OP_TAB;
        else                                       stat_o.op = OP_PUT;
      end
      REQ_CLEAR: stat_o.op = OP_CLEAR;
      REQ_ERASE: stat_o.op = OP_ERASE;
      REQ_READ:  stat_o.op = OP_READ;
      default:   stat_o.op = OP_PUT;
    endcase
  end

  // Status to the controller.
  assign stat_o.need_scroll = (cur_off >= ADDR_W'(VIS_CELLS));
  assign stat_o.blank_last  = (cnt_q == CNT_W'(1));
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.scnt_hit    = (scnt_inc >= (SCNT_W + 1)'(SCROLLS_BEFORE_COMPACT));
  assign stat_o.win_flat    = (vs_q <= ADDR_W'(BUFFER_CELLS - VIS_CELLS));
  assign stat_o.cp1_last    = (idx_q == split_q);
  assign stat_o.cp2_last    = (idx_q == split_q - CNT_W'(1));
  assign stat_o.tab_done    = (tab_q == '0);
  assign stat_o.init_last   = (ptr_q == ADDR_W'(BUFFER_CELLS - 1));
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_q;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = req_q.cell_addr;
    unique case (cmd_i.act)
      ACT_INIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = {ATTR_RESET, CH_SPACE};
      end
      ACT_PUT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {req_q.char_attr, cmd_i.put_space ? CH_SPACE : req_q.char_code};
      end
      ACT_BLANK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
      end
      ACT_CP1_WR, ACT_CP2_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(idx_q);
        ram_wdata = ram_rdata;
      end
      ACT_ERASE: begin
        ram_we    = (cursor_q != '0);
        ram_waddr = cursor_q - ADDR_W'(1);
      end
      ACT_CP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = vs_q + ADDR_W'(idx_q);
      end
      ACT_READ: ram_re = 1'b1;
      default: ;
    endcase
  end

  tcrs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (BUFFER_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Console state, sweep pointer and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      vs_q        <= '0;
      scnt_q      <= '0;
      ptr_q       <= '0;
      attr_q      <= ATTR_RESET;
      sc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      if (cmd_i.act == ACT_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.act)
        ACT_ACCEPT:   sc_q <= 1'b0;
        ACT_INIT_WR:  ptr_q <= ptr_q + ADDR_W'(1);
        ACT_PUT_WR:   cursor_q <= cursor_q + ADDR_W'(1);
        ACT_SCROLL: begin
          vs_q  <= vs_q + ADDR_W'(COLS);
          ptr_q <= vs_q + ADDR_W'(VIS_CELLS);
          sc_q  <= 1'b1;
        end
        ACT_BLANK_WR: ptr_q <= ptr_q + ADDR_W'(1);
        ACT_SCNT_INC: scnt_q <= scnt_inc[SCNT_W-1:0];
        ACT_CP_END: begin
          cursor_q <= cur_off;
          vs_q     <= '0;
          scnt_q   <= '0;
        end
        ACT_NEWLINE:  cursor_q <= cursor_q + (ADDR_W'(COLS) - ADDR_W'(col_q));
        ACT_RETURN:   cursor_q <= cursor_q - ADDR_W'(col_q);
        ACT_CLR_INIT: begin
          ptr_q    <= vs_q + ADDR_W'(row_off);
          cursor_q <= vs_q + ADDR_W'(row_off);
          scnt_q   <= '0;
        end
        ACT_ERASE: begin
          if (cursor_q != '0) cursor_q <= cursor_q - ADDR_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.act)
      ACT_ACCEPT:   req_q <= in_data_i;
      ACT_PUT_WR:   tab_q <= tab_q - 3'd1;
      ACT_SCROLL:   cnt_q <= CNT_W'(COLS);
      ACT_BLANK_WR: cnt_q <= cnt_q - CNT_W'(1);
      ACT_CP_INIT: begin
        split_q <= stat_o.win_flat ? CNT_W'(VIS_CELLS) : CNT_W'(tail_len);
        idx_q   <= stat_o.win_flat ? '0 : CNT_W'(VIS_CELLS - 1);
      end
      ACT_CP1_WR: begin
        // Wrapped part first, top down, then the part at the buffer end.
        if (idx_q == split_q) idx_q <= '0;
        else                  idx_q <= idx_q - CNT_W'(1);
      end
      ACT_CP2_WR:   idx_q <= idx_q + CNT_W'(1);
      ACT_DIV1:     prod_q <= PROD_W'(cur_off) * PROD_W'(DIV_MULT);
      ACT_DIV2:     col_q <= COL_W'(cur_off - ADDR_W'(ADDR_W'(quot) * ADDR_W'(COLS)));
      ACT_TAB_INIT: tab_q <= 3'd4 - {1'b0, col_q[1:0]};
      ACT_CLR_INIT: cnt_q <= CNT_W'(VIS_CELLS) - row_off;
      ACT_FINISH: begin
        out_q.cell_char      <= (req_q.req_type == REQ_READ) ? ram_rdata[7:0]  : 8'd0;
        out_q.cell_attribute <= (req_q.req_type == REQ_READ) ? ram_rdata[15:8] : 8'd0;
        out_q.cursor_pos     <= cursor_q;
        out_q.view_start_out <= vs_q;
        out_q.did_scroll     <= sc_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/text_console_ring_scroll.sv
// Text console over a ring-buffer cell memory: top level joining controller and datapath.
// in_ready_o is high only while idle, so a new request waits until the last one has finished.
// Scrolls, compactions and clears write their cells one at a time through the single
// write port of the cell RAM. After reset a clearing pass writes all BUFFER_CELLS cells
// with in_ready_o low.
module text_console_ring_scroll (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcrs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcrs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import tcrs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Request sequencer.
  tcrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Cell memory and console state.
  tcrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
